FILE: hw/rtl/gb5_pkg.sv
// Shared types and constants for the 5x5 Gaussian blur unit.
package gb5_pkg;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam int PIXEL_W       = 8;
   localparam int ROW_W         = 12;
   localparam int HEIGHT_W      = 13;
   localparam int CSR_W         = 13;
   localparam int IMAGE_WIDTH_W = 11;
   localparam int MIN_DIM       = 5;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RESET_DIM     = 800;
   localparam int LANES         = 4;
   localparam int ROWSUM_W      = 15;
   localparam int SUM_W         = 17;
   localparam int PROD_W        = 2 * SUM_W;

   // floor(s / 273) == (s * RECIP) >> RECIP_SHIFT for every s below 2^SUM_W used here
   localparam int               RECIP_SHIFT = 25;
   localparam logic [SUM_W-1:0] RECIP       = 17'd122911;

   localparam logic [5:0] KERNEL [5][5] = '{
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
      '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
      '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
   };

   typedef struct packed {
      op_type             op;
      logic [PIXEL_W-1:0] pixel;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] blurred;
      logic               frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic               is_flush;
      logic               emit;
      logic               interior;
      logic               frame_end;
      logic [1:0]         lane;
      logic [PIXEL_W-1:0] pixel;
   } stage1_type;

   typedef struct packed {
      logic               interior;
      logic               frame_end;
      logic [PIXEL_W-1:0] pass;
   } tail_type;

endpackage

FILE: hw/rtl/gb5_recip_div.sv
// Division of the kernel sum by 273 through a registered reciprocal product.
module gb5_recip_div
   import gb5_pkg::*;
(
   input  logic               clock,
   input  logic               load,
   input  logic [SUM_W-1:0]   sum,
   output logic [PIXEL_W-1:0] quotient
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(sum) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign quotient = prod_ff[RECIP_SHIFT +: PIXEL_W];

endmodule

FILE: hw/rtl/gaussian_blur_5x5_unit.sv
// Top level of the streaming 5x5 Gaussian blur unit.
//
// Input words (req_) carry one raster pixel each, or a flush. Set image_width and
// image_height on the csr_ port while idle; a write restarts the frame.
// One word is taken per clock; req_stall rises only when the six-stage pipeline is
// full behind a stalled rsp_ output register, so stalls on the result side back up
// stage by stage, and an output word held by rsp_stall keeps its value.
// In raster terms results lag input by two rows plus two pixels: the first 2*W+2
// pixels of a frame give none. After the last pixel, 2*W+2 flush words drain the
// bottom border, the final one marked frame_end; a flush with nothing pending
// gives no result.
// Throughput is one word per cycle, set by the single-port line store: each pixel
// reads all four line bytes of its column and writes one byte in the same cycle.
// Interior pixels go through row sums, a total and a reciprocal multiply by 1/273;
// border pixels pass through unchanged.
// Reset clears the counters, the window and the pipeline and loads 800 x 800.
// The line store is not cleared; no output reads a byte not written in its frame.
module gaussian_blur_5x5_unit
   import gb5_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int WX      = WW + 1;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int PW      = $clog2(2 * MAX_WIDTH + 3);
   localparam int RESET_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;

   // configuration and raster counters
   logic [WW-1:0]       eff_w_ff, eff_w_in;
   logic [HEIGHT_W-1:0] eff_h_ff, eff_h_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PW-1:0]       pend_ff, pend_in;
   logic [CW-1:0]       dcol_ff, dcol_in;
   logic [1:0]          dlane_ff, dlane_in;

   logic [HEIGHT_W-1:0] w_clamp, h_clamp, w_raw;

   // accept stage
   logic                restart, is_flush, accept, s1_take;
   logic [ROW_W-1:0]    r, ro;
   logic [CW-1:0]       c, co;
   logic                emit_pix, interior_pix;
   logic [WW-1:0]       c_inc, d_inc;
   logic [HEIGHT_W-1:0] r_inc, h_m3;
   logic                c_wrap, r_wrap, d_wrap;
   logic [PW-1:0]       pend_init;
   logic [CW-1:0]       mem_addr;
   logic                mem_wr;
   stage1_type          s1_in;

   // line store
   logic [LANES-1:0][PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [LANES-1:0][PIXEL_W-1:0] rdata_ff;

   // pipeline
   logic                           v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                           mv1, mv2, mv3, mv4, mv5, space1;
   stage1_type                     s1_ff;
   logic                           flush2_ff, int2_ff, fe2_ff;
   logic [PIXEL_W-1:0]             byte2_ff;
   logic [4:0][4:0][PIXEL_W-1:0]   window_ff;
   logic [4:0][PIXEL_W-1:0]        colv;
   logic [ROWSUM_W-1:0]            rowsum [5];
   logic [ROWSUM_W-1:0]            rows3_ff [5];
   tail_type                       t3_ff, t4_ff, t5_ff;
   logic [SUM_W-1:0]               sum4_in, sum4_ff;
   logic [PIXEL_W-1:0]             quotient;
   logic                           rsp_valid_ff;
   rsp_word_type                   rsp_word_ff;

   // csr clamping
   always_comb begin
      w_raw = HEIGHT_W'(csr_wdata[IMAGE_WIDTH_W-1:0]);
      if (w_raw < HEIGHT_W'(MIN_DIM)) begin
         w_clamp = HEIGHT_W'(MIN_DIM);
      end else if (w_raw > HEIGHT_W'(MAX_WIDTH)) begin
         w_clamp = HEIGHT_W'(MAX_WIDTH);
      end else begin
         w_clamp = w_raw;
      end
      if (csr_wdata < HEIGHT_W'(MIN_DIM)) begin
         h_clamp = HEIGHT_W'(MIN_DIM);
      end else if (csr_wdata > HEIGHT_W'(MAX_HEIGHT)) begin
         h_clamp = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_clamp = csr_wdata;
      end
   end

   // handshake chain
   assign mv5       = v5_ff && (!rsp_valid_ff || !rsp_stall);
   assign mv4       = v4_ff && (!v5_ff || mv5);
   assign mv3       = v3_ff && (!v4_ff || mv4);
   assign mv2       = v2_ff && (!v3_ff || mv3);
   assign mv1       = v1_ff && (!v2_ff || mv2);
   assign space1    = !v1_ff || mv1;
   assign req_stall = !space1;
   assign accept    = req_valid && space1;

   // accept stage decode
   always_comb begin
      restart  = (pend_ff != '0);
      is_flush = (req_word.op == OP_FLUSH);
      r        = restart ? '0 : row_ff;
      c        = restart ? '0 : col_ff;

      emit_pix = (r >= ROW_W'(3)) || ((r == ROW_W'(2)) && (c >= CW'(2)));
      if (c >= CW'(2)) begin
         ro = r - ROW_W'(2);
         co = c - CW'(2);
      end else begin
         ro = r - ROW_W'(3);
         co = CW'(eff_w_ff - WW'(2) + WW'(c));
      end
      interior_pix = (ro >= ROW_W'(2))
                  && ((HEIGHT_W'(ro) + HEIGHT_W'(3)) <= eff_h_ff)
                  && (co >= CW'(2))
                  && ((WX'(co) + WX'(3)) <= WX'(eff_w_ff));

      c_inc     = WW'(c) + WW'(1);
      c_wrap    = (c_inc >= eff_w_ff);
      r_inc     = HEIGHT_W'(r) + HEIGHT_W'(1);
      r_wrap    = (r_inc >= eff_h_ff);
      d_inc     = WW'(dcol_ff) + WW'(1);
      d_wrap    = (d_inc >= eff_w_ff);
      pend_init = PW'({eff_w_ff, 1'b0}) + PW'(2);
      h_m3      = eff_h_ff - HEIGHT_W'(3);

      mem_addr  = is_flush ? dcol_ff : c;
      mem_wr    = accept && !is_flush;
      s1_take   = !is_flush || restart;

      s1_in.is_flush  = is_flush;
      s1_in.emit      = is_flush ? 1'b1 : emit_pix;
      s1_in.interior  = !is_flush && interior_pix;
      s1_in.frame_end = is_flush && (pend_ff == PW'(1));
      s1_in.lane      = is_flush ? dlane_ff : r[1:0];
      s1_in.pixel     = req_word.pixel;
   end

   // counter next state
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      dcol_in  = dcol_ff;
      dlane_in = dlane_ff;
      if (csr_wr_en) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  eff_w_in = WW'(w_clamp);
            CSR_IMAGE_HEIGHT: eff_h_in = h_clamp;
            default:          eff_w_in = eff_w_ff;
         endcase
      end else if (accept && !is_flush) begin
         col_in  = c_wrap ? '0 : c_inc[CW-1:0];
         row_in  = c_wrap ? (r_wrap ? '0 : r_inc[ROW_W-1:0]) : r;
         pend_in = (c_wrap && r_wrap) ? pend_init : '0;
         if (c_wrap && r_wrap) begin
            dcol_in  = CW'(eff_w_ff - WW'(2));
            dlane_in = h_m3[1:0];
         end
      end else if (accept && restart) begin
         pend_in  = pend_ff - PW'(1);
         dcol_in  = d_wrap ? '0 : d_inc[CW-1:0];
         dlane_in = d_wrap ? dlane_ff + 2'd1 : dlane_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= WW'(RESET_W);
         eff_h_ff <= HEIGHT_W'(RESET_DIM);
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
         dcol_ff  <= '0;
         dlane_ff <= '0;
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         dcol_ff  <= dcol_in;
         dlane_ff <= dlane_in;
      end
   end

   // four line bytes per column; the read sees the byte before this write
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[mem_addr][r[1:0]] <= req_word.pixel;
      end
      if (accept) begin
         rdata_ff <= line_mem[mem_addr];
      end
   end

   // column entering the window: older rows from the store, newest from the word
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         colv[k] = rdata_ff[2'(s1_ff.lane + 2'(k))];
      end
      colv[4] = s1_ff.pixel;
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         rowsum[i] = '0;
         for (int j = 0; j < 5; j++) begin
            rowsum[i] = rowsum[i]
                      + ROWSUM_W'(window_ff[i][j]) * ROWSUM_W'(KERNEL[i][j]);
         end
      end
   end

   always_comb begin
      sum4_in = '0;
      for (int i = 0; i < 5; i++) begin
         sum4_in = sum4_in + SUM_W'(rows3_ff[i]);
      end
   end

   // valids and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         if (accept && s1_take) begin
            v1_ff <= 1'b1;
         end else if (mv1) begin
            v1_ff <= 1'b0;
         end
         if (mv1) begin
            v2_ff <= s1_ff.emit;
         end else if (mv2) begin
            v2_ff <= 1'b0;
         end
         if (mv2) begin
            v3_ff <= 1'b1;
         end else if (mv3) begin
            v3_ff <= 1'b0;
         end
         if (mv3) begin
            v4_ff <= 1'b1;
         end else if (mv4) begin
            v4_ff <= 1'b0;
         end
         if (mv4) begin
            v5_ff <= 1'b1;
         end else if (mv5) begin
            v5_ff <= 1'b0;
         end
         if (mv5) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mv1 && !s1_ff.is_flush) begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  window_ff[i][j] <= window_ff[i][j+1];
               end
               window_ff[i][4] <= colv[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (mv1) begin
         flush2_ff <= s1_ff.is_flush;
         int2_ff   <= s1_ff.interior;
         fe2_ff    <= s1_ff.frame_end;
         byte2_ff  <= rdata_ff[s1_ff.lane];
      end
      if (mv2) begin
         rows3_ff           <= rowsum;
         t3_ff.interior     <= int2_ff;
         t3_ff.frame_end    <= fe2_ff;
         t3_ff.pass         <= flush2_ff ? byte2_ff : window_ff[2][2];
      end
      if (mv3) begin
         sum4_ff <= sum4_in;
         t4_ff   <= t3_ff;
      end
      if (mv4) begin
         t5_ff <= t4_ff;
      end
      if (mv5) begin
         rsp_word_ff.blurred   <= t5_ff.interior ? quotient : t5_ff.pass;
         rsp_word_ff.frame_end <= t5_ff.frame_end;
      end
   end

   gb5_recip_div u_div (
      .clock    (clock),
      .load     (mv4),
      .sum      (sum4_ff),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !mv2) |=> $stable(window_ff))
      else $error("window moved under a held result");

   a_rdata_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !mv1) |=> $stable(rdata_ff))
      else $error("line store data lost while stage one waits");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < eff_w_ff)
      else $error("column counter beyond row width");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> (WW'(dcol_ff) < eff_w_ff))
      else $error("drain column beyond row width");

endmodule
